### rtl/skers_pkg.sv
package skers_pkg;

	localparam int KEY_W  = 32;
	localparam int MODE_W = 2;
	localparam int OUT_W  = 11;

	typedef enum logic [MODE_W-1:0] {
		MODE_NEW    = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_QUERY  = 2'd2
	} mode_t;

	typedef struct packed {
		logic             valid;
		logic [OUT_W-1:0] lower;
		logic [OUT_W-1:0] upper;
	} result_t;

endpackage

### rtl/skers_key_mem.sv
module skers_key_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [skers_pkg::KEY_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [skers_pkg::KEY_W-1:0] rdata
);
	import skers_pkg::*;

	logic [KEY_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/skers_search_seq.sv
module skers_search_seq #(
	parameter int AW = 10,
	parameter int CW = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        query_start,
	input  logic [skers_pkg::KEY_W-1:0] query_key,
	input  logic [CW-1:0]               count,
	output logic                        busy,
	output logic [AW-1:0]               rd_addr,
	input  logic [skers_pkg::KEY_W-1:0] rd_data,
	output skers_pkg::result_t          result
);
	import skers_pkg::*;

	localparam int EW = (CW > OUT_W) ? CW : OUT_W;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_PROBE = 3'b010,
		ST_CMP   = 3'b100
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    lo_q;
	logic [CW-1:0]    hi_q;
	logic [CW-1:0]    mid_q;
	logic [CW-1:0]    lower_q;
	logic [KEY_W-1:0] key_q;
	logic             strict_q;
	logic             res_valid_q;
	logic [OUT_W-1:0] res_lower_q;
	logic [OUT_W-1:0] res_upper_q;
	logic [CW:0]      sum;
	logic [CW-1:0]    mid;
	logic             lt;
	logic             eq;
	logic             go_right;
	logic [EW-1:0]    lo_ext;
	logic [EW-1:0]    lower_ext;

	assign sum      = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = sum[CW:1];
	assign rd_addr  = mid[AW-1:0];
	assign busy     = (state_q != ST_IDLE);

	// shared compare unit, signed order
	assign lt       = $signed(rd_data) < $signed(key_q);
	assign eq       = (rd_data == key_q);
	assign go_right = strict_q ? lt : (lt | eq);

	assign lo_ext    = EW'(lo_q);
	assign lower_ext = EW'(lower_q);

	assign result = '{valid: res_valid_q, lower: res_lower_q, upper: res_upper_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (query_start) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (lo_q < hi_q) begin
						state_q <= ST_CMP;
					end else if (!strict_q) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_CMP: begin
					state_q <= ST_PROBE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				key_q    <= query_key;
				lo_q     <= '0;
				hi_q     <= count;
				strict_q <= 1'b1;
			end
			ST_PROBE: begin
				if (lo_q < hi_q) begin
					mid_q <= mid;
				end else if (strict_q) begin
					// lower bound done, rerun for upper bound
					lower_q  <= lo_q;
					lo_q     <= '0;
					hi_q     <= count;
					strict_q <= 1'b0;
				end else begin
					res_lower_q <= lower_ext[OUT_W-1:0];
					res_upper_q <= lo_ext[OUT_W-1:0];
				end
			end
			ST_CMP: begin
				if (go_right) begin
					lo_q <= mid_q + CW'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			default: begin
				lo_q <= '0;
			end
		endcase
	end

	a_lo_le_hi: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (lo_q <= mid_q) && (mid_q < hi_q))
		else $error("probe index outside search window");

	a_hi_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (hi_q <= count))
		else $error("search window past entry count");

	a_cmp_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |=> (state_q == ST_PROBE))
		else $error("compare not followed by probe");

	a_result_from_probe: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ($past(state_q) == ST_PROBE) && (state_q == ST_IDLE))
		else $error("result outside end of search");

endmodule

### rtl/sorted_key_equal_range_search_unit.sv
// a query runs a lower bound search, then an upper bound search; each probe
//   steps through PROBE and CMP, and done is registered from the result
// the probe loop is set by the key memory's registered read port
// new table and append beats write the key store directly and never raise busy
// reset clears the entry count and control, key store contents stay undefined
// done pulses for one cycle, the receiver cannot stall
module sorted_key_equal_range_search_unit #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [skers_pkg::MODE_W-1:0] mode,
	input  logic signed [skers_pkg::KEY_W-1:0] key,
	output logic                         done,
	output logic [skers_pkg::OUT_W-1:0]  lower_index,
	output logic [skers_pkg::OUT_W-1:0]  upper_index
);
	import skers_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic             accept;
	logic [CW-1:0]    count_q;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	logic [KEY_W-1:0] rdata;
	logic             full;
	result_t          result;

	assign accept = start && !busy;
	assign full   = (count_q == CW'(TABLE_DEPTH));

	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		case (mode)
			MODE_NEW: begin
				we    = accept;
				waddr = '0;
			end
			MODE_APPEND: begin
				we = accept && !full;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (we) begin
			count_q <= (mode == MODE_NEW) ? CW'(1) : count_q + CW'(1);
		end
	end

	skers_key_mem #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(key),
		.raddr(raddr),
		.rdata(rdata)
	);

	skers_search_seq #(
		.AW(AW),
		.CW(CW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.query_start(accept && (mode == MODE_QUERY)),
		.query_key  (key),
		.count      (count_q),
		.busy       (busy),
		.rd_addr    (raddr),
		.rd_data    (rdata),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			lower_index <= result.lower;
			upper_index <= result.upper;
		end
	end

endmodule

### verif/sorted_key_equal_range_search_unit_tb.sv
module sorted_key_equal_range_search_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import skers_pkg::*;

	localparam int DEPTH = 1024;
	localparam int ITEMS = 1900;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int KEY_MIN = 32'h8000_0000;
	localparam int KEY_MAX = 32'h7fff_ffff;

	typedef struct {
		logic [MODE_W-1:0] mode;
		int                key;
		bit                drain;
	} beat_t;

	typedef struct {
		logic [OUT_W-1:0] lower;
		logic [OUT_W-1:0] upper;
		int               key;
	} bound_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [MODE_W-1:0] mode = MODE_NEW;
	logic signed [KEY_W-1:0] key = '0;
	logic done;
	logic [OUT_W-1:0] lower_index;
	logic [OUT_W-1:0] upper_index;

	// shadow copy of the key table
	logic signed [KEY_W-1:0] shadow_keys [DEPTH];
	int shadow_count = 0;

	beat_t beats_to_send[$];
	bound_pair_t expected_ranges[$];
	int table_keys[$];

	int planned_beats = 0;
	int mismatches = 0;
	int queries_sent = 0;
	int table_writes = 0;
	int ignored_beats = 0;
	int largest_table = 0;
	int ranges_checked = 0;
	int burst_left = 0;
	int gap_left = 0;

	sorted_key_equal_range_search_unit #(
		.TABLE_DEPTH(DEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.key         (key),
		.done        (done),
		.lower_index (lower_index),
		.upper_index (upper_index)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// binary search over [0, count): strict gives the lower bound, else the upper
	function automatic logic [OUT_W-1:0] bound_of(input logic signed [KEY_W-1:0] k,
			input bit strict);
		int lo;
		int hi;
		int mid;
		bit go_right;
		lo = 0;
		hi = shadow_count;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			go_right = strict ? (shadow_keys[mid] < k) : (shadow_keys[mid] <= k);
			if (go_right)
				lo = mid + 1;
			else
				hi = mid;
		end
		return OUT_W'(lo);
	endfunction

	task automatic apply_to_table(input logic [MODE_W-1:0] m,
			input logic signed [KEY_W-1:0] k);
		bound_pair_t range;
		case (m)
			MODE_NEW: begin
				shadow_keys[0] = k;
				shadow_count = 1;
				table_writes++;
			end
			MODE_APPEND: begin
				if (shadow_count < DEPTH) begin
					shadow_keys[shadow_count] = k;
					shadow_count++;
					table_writes++;
				end else begin
					ignored_beats++;
				end
			end
			MODE_QUERY: begin
				range.lower = bound_of(k, 1'b1);
				range.upper = bound_of(k, 1'b0);
				range.key = k;
				expected_ranges.push_back(range);
				queries_sent++;
			end
			default: ignored_beats++;
		endcase
		if (shadow_count > largest_table)
			largest_table = shadow_count;
	endtask

	task automatic queue_beat(input logic [MODE_W-1:0] m, input int k);
		beat_t b;
		b.mode = m;
		b.key = k;
		b.drain = 1'b0;
		beats_to_send.push_back(b);
		if (m != MODE_UNUSED)
			planned_beats++;
	endtask

	// marker: the driver holds off until every pending range is back
	task automatic queue_drain();
		beat_t b;
		b.mode = MODE_NEW;
		b.key = 0;
		b.drain = 1'b1;
		beats_to_send.push_back(b);
	endtask

	// sorted table with duplicates, loaded as new + appends
	task automatic add_table(input int n);
		int v;
		int j;
		int tmp;
		int style;
		int base;
		style = $urandom_range(0, 3);
		base = $urandom;
		table_keys.delete();
		for (int i = 0; i < n; i++) begin
			case (style)
				0: v = $urandom;
				1: v = base + $urandom_range(0, 2 * n);
				2: v = KEY_MIN + $urandom_range(0, 3 * n);
				default: v = KEY_MAX - $urandom_range(0, 3 * n);
			endcase
			if (i > 0 && $urandom_range(0, 4) == 0)
				v = table_keys[$urandom_range(0, i - 1)];
			table_keys.push_back(v);
			j = i;
			while (j > 0 && table_keys[j-1] > table_keys[j]) begin
				tmp = table_keys[j-1];
				table_keys[j-1] = table_keys[j];
				table_keys[j] = tmp;
				j--;
			end
		end
		queue_beat(MODE_NEW, table_keys[0]);
		for (int i = 1; i < n; i++)
			queue_beat(MODE_APPEND, table_keys[i]);
	endtask

	function automatic int probe_key();
		int k;
		k = (table_keys.size() != 0) ? table_keys[$urandom_range(0, table_keys.size() - 1)]
			: int'($urandom);
		case ($urandom_range(0, 7))
			4: k = k + 1;
			5: k = k - 1;
			6: k = $urandom;
			7: k = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
			default: ;
		endcase
		return k;
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive_proc
		beat_t nxt;
		bit take;
		if (!arst_n) begin
			start <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (start && !busy)
				apply_to_table(mode, key);
			if (!start || !busy) begin
				take = 1'b0;
				if (gap_left != 0) begin
					gap_left--;
				end else if (beats_to_send.size() != 0) begin
					if (beats_to_send[0].drain) begin
						if (expected_ranges.size() == 0 && !busy)
							void'(beats_to_send.pop_front());
					end else begin
						nxt = beats_to_send.pop_front();
						take = 1'b1;
						if (burst_left <= 1) begin
							burst_left = $urandom_range(1, 40);
							case ($urandom_range(0, 7))
								0, 1, 2: gap_left = 0;
								3, 4, 5: gap_left = $urandom_range(1, 4);
								6: gap_left = $urandom_range(5, 20);
								default: gap_left = $urandom_range(21, 60);
							endcase
						end else begin
							burst_left--;
						end
					end
				end
				start <= take;
				if (take) begin
					mode <= nxt.mode;
					key <= nxt.key;
				end
			end
		end
	end

	always @(posedge clk) begin : check_proc
		bound_pair_t want;
		if (arst_n && done) begin
			ranges_checked++;
			if (expected_ranges.size() == 0) begin
				flag_mismatch($sformatf("range beat lower %0d upper %0d with no query pending",
					lower_index, upper_index));
			end else begin
				want = expected_ranges.pop_front();
				if (lower_index !== want.lower)
					flag_mismatch($sformatf("key %0d lower got %0d want %0d",
						want.key, lower_index, want.lower));
				if (upper_index !== want.upper)
					flag_mismatch($sformatf("key %0d upper got %0d want %0d",
						want.key, upper_index, want.upper));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d beats unsent, %0d ranges pending",
			beats_to_send.size(), expected_ranges.size());
		$display("sorted_key_equal_range_search_unit verification failed");
		$finish;
	end

	initial begin : stim_proc
		int n;
		int k;
		// empty table, append after reset, extremes, duplicates, unused mode
		queue_beat(MODE_QUERY, 0);
		queue_beat(MODE_APPEND, KEY_MIN);
		queue_beat(MODE_QUERY, KEY_MIN);
		queue_beat(MODE_NEW, -5);
		queue_beat(MODE_APPEND, -5);
		queue_beat(MODE_APPEND, 0);
		queue_beat(MODE_APPEND, 7);
		queue_beat(MODE_APPEND, KEY_MAX);
		queue_beat(MODE_UNUSED, 3);
		queue_beat(MODE_QUERY, -5);
		queue_beat(MODE_QUERY, KEY_MIN);
		queue_beat(MODE_QUERY, KEY_MAX);
		queue_beat(MODE_QUERY, -6);
		queue_beat(MODE_QUERY, 1);
		queue_beat(MODE_QUERY, -1);
		// out of order entry
		queue_beat(MODE_APPEND, 3);
		queue_beat(MODE_QUERY, 3);
		queue_beat(MODE_QUERY, 7);
		queue_beat(MODE_NEW, KEY_MAX);
		queue_beat(MODE_QUERY, KEY_MAX);
		queue_beat(MODE_QUERY, KEY_MIN);
		queue_drain();

		// full table, then appends past capacity
		add_table(DEPTH);
		repeat (6) queue_beat(MODE_APPEND, KEY_MAX);
		repeat (30) queue_beat(MODE_QUERY, probe_key());
		queue_drain();

		while (planned_beats < ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(3, 10))
					queue_beat(MODE_W'($urandom_range(0, 3)),
						$urandom_range(0, 1) ? probe_key() : int'($urandom));
			end else begin
				n = ($urandom_range(0, 14) == 0) ? $urandom_range(25, 200)
					: $urandom_range(1, 20);
				add_table(n);
				repeat ($urandom_range(1, 8)) queue_beat(MODE_QUERY, probe_key());
				if ($urandom_range(0, 3) == 0) begin
					k = table_keys[table_keys.size() - 1];
					if (k < KEY_MAX - 4)
						k = k + $urandom_range(0, 3);
					queue_beat(MODE_APPEND, k);
					table_keys.push_back(k);
					repeat ($urandom_range(1, 3)) queue_beat(MODE_QUERY, probe_key());
				end
			end
			if ($urandom_range(0, 11) == 0)
				queue_drain();
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do begin
			@(posedge clk);
			#1;
		end while (beats_to_send.size() != 0 || start);
		while (expected_ranges.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d queries, %0d table writes, %0d ignored beats, largest table %0d",
			queries_sent, table_writes, ignored_beats, largest_table);
		$display("%0d ranges checked, %0d mismatches", ranges_checked, mismatches);
		if (mismatches == 0)
			$display("sorted_key_equal_range_search_unit verification clean");
		else
			$display("sorted_key_equal_range_search_unit verification failed");
		$finish;
	end

endmodule

### files.f
rtl/skers_pkg.sv
rtl/skers_key_mem.sv
rtl/skers_search_seq.sv
rtl/sorted_key_equal_range_search_unit.sv
verif/sorted_key_equal_range_search_unit_tb.sv
